FILE: sv/bump_heap_allocator_with_holes_core_macros.svh
// Assertion macros for the bump heap allocator core.
// Included by the top level; no other dependencies.
`ifndef BUMP_HEAP_ALLOCATOR_WITH_HOLES_CORE_MACROS_SVH
`define BUMP_HEAP_ALLOCATOR_WITH_HOLES_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset
`define BHAH_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the cycle after an antecedent
`define BHAH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/bhah_pkg.sv
// Shared types, constants and helper functions of the bump heap allocator.
// No dependencies; used by the interfaces, the region unit, the core and the bench.
package bhah_pkg;

   localparam int unsigned OPEN_BLOCKS_DEF      = 20;
   localparam int unsigned RESERVED_REGIONS_DEF = 6;
   localparam int unsigned SLOT_W               = 3;
   localparam int unsigned ADDR_BITS            = 32;
   localparam int unsigned ALIGN_W              = 17;
   localparam int unsigned STATUS_W             = 2;
   localparam int unsigned CSR_IDX_W            = 2;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [ALIGN_W-1:0]   align_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Register reset values
   localparam addr_type HEAP_BASE_RST  = 32'h8004_181C;
   localparam addr_type HEAP_LIMIT_RST = 32'h8044_C000;
   localparam addr_type IMAGE_END_RST  = 32'h8038_05E0;

   // Register indexes
   localparam csr_idx_type CSR_HEAP_BASE  = 2'd0;
   localparam csr_idx_type CSR_HEAP_LIMIT = 2'd1;
   localparam csr_idx_type CSR_IMAGE_END  = 2'd2;

   // Transaction kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_ADD   = 1'b1;

   // Result status codes
   localparam status_type STAT_HEAP     = 2'd0;
   localparam status_type STAT_OVERFLOW = 2'd1;
   localparam status_type STAT_NO_MEM   = 2'd2;
   localparam status_type STAT_REFUSED  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROUND,
      ST_SUM,
      ST_CHECK,
      ST_JUMP,
      ST_COMMIT,
      ST_OVF_READ,
      ST_OVF_LOAD,
      ST_OVF_ROUND,
      ST_OVF_SUM,
      ST_OVF_TEST,
      ST_DONE
   } state_type;

   // One entry of the open-block table
   typedef struct packed {
      addr_type blk_first;
      addr_type blk_limit;
   } open_block_type;

   // Result of testing two addresses against one reserved region
   typedef struct packed {
      logic     hit_a;
      logic     hit_b;
      addr_type hi;
   } region_hit_type;

   // Lower bound of a reserved region slot
   function automatic addr_type region_lo(input logic [SLOT_W-1:0] slot);
      addr_type lo;
      unique case (slot)
         3'd0:    lo = 32'h800D_A800;
         3'd1:    lo = 32'h8010_0000;
         3'd2:    lo = 32'h803D_A800;
         3'd3:    lo = 32'h8000_0400;
         3'd4:    lo = 32'h8020_0000;
         3'd5:    lo = 32'h8000_0000;
         default: lo = '0;
      endcase
      return lo;
   endfunction

   // Exclusive upper bound of a reserved region slot; the image region is live
   function automatic addr_type region_hi(input logic [SLOT_W-1:0] slot,
                                          input addr_type image_end);
      addr_type hi;
      unique case (slot)
         3'd0:    hi = 32'h8010_0000;
         3'd1:    hi = 32'h8012_5800;
         3'd2:    hi = 32'h8040_0000;
         3'd3:    hi = 32'h8004_17DC;
         3'd4:    hi = image_end;
         3'd5:    hi = 32'h8000_0400;
         default: hi = '0;
      endcase
      return hi;
   endfunction

   // Round up to the alignment; zero alignment acts as one
   function automatic addr_type round_up(input addr_type p, input align_type a);
      addr_type mask;
      mask = (a == '0) ? '0 : (addr_type'(a) - addr_type'(1));
      return (p + mask) & ~mask;
   endfunction

endpackage

FILE: sv/bhah_if.sv
// Handshake channel interfaces of the bump heap allocator.
// Depends on bhah_pkg for payload types.
interface bhah_req_if;
   logic                  valid;
   logic                  ready;
   logic                  kind;
   bhah_pkg::addr_type    request_size;
   bhah_pkg::align_type   align_bytes;
   bhah_pkg::addr_type    block_first;
   bhah_pkg::addr_type    block_limit;

   modport source (output valid, kind, request_size, align_bytes, block_first,
                   block_limit, input ready);
   modport sink   (input valid, kind, request_size, align_bytes, block_first,
                   block_limit, output ready);
endinterface

interface bhah_rsp_if;
   logic                  valid;
   logic                  ready;
   bhah_pkg::addr_type    granted_address;
   bhah_pkg::status_type  status;

   modport source (output valid, granted_address, status, input ready);
   modport sink   (input valid, granted_address, status, output ready);
endinterface

interface bhah_csr_if;
   logic                  valid;
   logic                  ready;
   bhah_pkg::csr_idx_type index;
   bhah_pkg::addr_type    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/bhah_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhah_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 20
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bhah_region_unit.sv
// Shared reserved-region compare unit: tests two addresses against one slot.
// Depends on bhah_pkg for the region table and result struct.
module bhah_region_unit (
   input  logic [bhah_pkg::SLOT_W-1:0] slot,
   input  bhah_pkg::addr_type          addr_a,
   input  bhah_pkg::addr_type          addr_b,
   input  bhah_pkg::addr_type          image_end,
   output bhah_pkg::region_hit_type    hit
);

   bhah_pkg::addr_type lo;
   bhah_pkg::addr_type hi;

   // Look up the bounds and compare both addresses
   always_comb begin
      lo        = bhah_pkg::region_lo(slot);
      hi        = bhah_pkg::region_hi(slot, image_end);
      hit.hit_a = (addr_a >= lo) && (addr_a < hi);
      hit.hit_b = (addr_b >= lo) && (addr_b < hi);
      hit.hi    = hi;
   end

endmodule

FILE: sv/bump_heap_allocator_with_holes_core.sv
// Bump heap allocator with reserved holes and an overflow open-block table.
// One transaction at a time. An add-block scans the reserved regions in turn. A
// heap allocate rounds, sums and scans the regions; a hit hops over regions in
// the jump state with the shared region compare unit, then sums again. Overflow
// tries each open block through the read, load, round, sum and test states.
// Synchronous reset loads the register reset values and empties the table.
module bump_heap_allocator_with_holes_core #(
   parameter int unsigned OPEN_BLOCKS      = bhah_pkg::OPEN_BLOCKS_DEF,
   parameter int unsigned RESERVED_REGIONS = bhah_pkg::RESERVED_REGIONS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bhah_req_if.sink          req_chan,
   bhah_rsp_if.source        rsp_chan,
   bhah_csr_if.sink          csr_chan
);

`include "bump_heap_allocator_with_holes_core_macros.svh"

   localparam int unsigned CNT_W   = $clog2(OPEN_BLOCKS + 1);
   localparam int unsigned ADDR_W  = (OPEN_BLOCKS > 1) ? $clog2(OPEN_BLOCKS) : 1;
   localparam int unsigned RC_W    = $clog2(RESERVED_REGIONS + 1);
   localparam int unsigned ENTRY_W = $bits(bhah_pkg::open_block_type);

   // Control and architectural state
   bhah_pkg::state_type    state_ff, state_in;
   bhah_pkg::addr_type     heap_base_ff, heap_base_in;
   bhah_pkg::addr_type     heap_limit_ff, heap_limit_in;
   bhah_pkg::addr_type     image_end_ff, image_end_in;
   bhah_pkg::addr_type     heap_ptr_ff, heap_ptr_in;
   bhah_pkg::addr_type     ovf_bytes_ff, ovf_bytes_in;
   logic [CNT_W-1:0]       open_idx_ff, open_idx_in;
   logic [CNT_W-1:0]       open_count_ff, open_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Working registers of the current transaction
   logic                   kind_ff, kind_in;
   bhah_pkg::addr_type     size_ff, size_in;
   bhah_pkg::align_type    align_ff, align_in;
   bhah_pkg::addr_type     cand_ff, cand_in;
   bhah_pkg::addr_type     cand_end_ff, cand_end_in;
   logic [RC_W-1:0]        region_ff, region_in;
   logic                   jumped_ff, jumped_in;
   bhah_pkg::addr_type     res_addr_ff, res_addr_in;
   bhah_pkg::status_type   res_status_ff, res_status_in;
   bhah_pkg::addr_type     rsp_addr_ff, rsp_addr_in;
   bhah_pkg::status_type   rsp_status_ff, rsp_status_in;

   logic                   req_fire;
   logic                   done_xfer;
   logic                   region_last;
   logic                   region_end;
   logic                   idx_live;
   bhah_pkg::region_hit_type hit;

   logic                   ram_we;
   logic                   ram_re;
   logic [ENTRY_W-1:0]     ram_wdata;
   logic [ENTRY_W-1:0]     ram_rdata;
   bhah_pkg::open_block_type ram_entry;

   assign req_fire    = req_chan.valid && req_chan.ready;
   assign done_xfer   = (state_ff == bhah_pkg::ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign region_last = (region_ff == RC_W'(RESERVED_REGIONS - 1));
   assign region_end  = (region_ff == RC_W'(RESERVED_REGIONS));
   assign idx_live    = (open_idx_ff < open_count_ff);
   assign ram_wdata   = {cand_ff, cand_end_ff};
   assign ram_entry   = ram_rdata;

   // Shared region compare unit
   bhah_region_unit u_region (
      .slot      (bhah_pkg::SLOT_W'(region_ff)),
      .addr_a    (cand_ff),
      .addr_b    (cand_end_ff),
      .image_end (image_end_ff),
      .hit       (hit)
   );

   // Open-block table
   bhah_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (OPEN_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (open_count_ff[ADDR_W-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (open_idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bhah_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == bhah_pkg::KIND_ADD) begin
                  if ((req_chan.block_first == req_chan.block_limit) ||
                      (open_count_ff >= CNT_W'(OPEN_BLOCKS))) begin
                     state_in = bhah_pkg::ST_DONE;
                  end else begin
                     state_in = bhah_pkg::ST_CHECK;
                  end
               end else if (ovf_bytes_ff != '0) begin
                  state_in = bhah_pkg::ST_OVF_ROUND;
               end else begin
                  state_in = bhah_pkg::ST_ROUND;
               end
            end
         end
         bhah_pkg::ST_ROUND: state_in = bhah_pkg::ST_SUM;
         bhah_pkg::ST_SUM: begin
            state_in = jumped_ff ? bhah_pkg::ST_COMMIT : bhah_pkg::ST_CHECK;
         end
         bhah_pkg::ST_CHECK: begin
            if (hit.hit_a || hit.hit_b) begin
               state_in = (kind_ff == bhah_pkg::KIND_ADD) ? bhah_pkg::ST_DONE
                                                          : bhah_pkg::ST_JUMP;
            end else if (region_last) begin
               state_in = (kind_ff == bhah_pkg::KIND_ADD) ? bhah_pkg::ST_DONE
                                                          : bhah_pkg::ST_COMMIT;
            end
         end
         bhah_pkg::ST_JUMP: begin
            if (region_end) begin
               state_in = bhah_pkg::ST_SUM;
            end
         end
         bhah_pkg::ST_COMMIT: begin
            state_in = (cand_end_ff >= heap_limit_ff) ? bhah_pkg::ST_OVF_READ
                                                      : bhah_pkg::ST_DONE;
         end
         bhah_pkg::ST_OVF_READ:  state_in = bhah_pkg::ST_OVF_LOAD;
         bhah_pkg::ST_OVF_LOAD:  state_in = bhah_pkg::ST_OVF_ROUND;
         bhah_pkg::ST_OVF_ROUND: begin
            state_in = idx_live ? bhah_pkg::ST_OVF_SUM : bhah_pkg::ST_DONE;
         end
         bhah_pkg::ST_OVF_SUM:   state_in = bhah_pkg::ST_OVF_TEST;
         bhah_pkg::ST_OVF_TEST: begin
            state_in = (ram_entry.blk_limit >= cand_end_ff) ? bhah_pkg::ST_DONE
                                                            : bhah_pkg::ST_OVF_READ;
         end
         bhah_pkg::ST_DONE: begin
            if (done_xfer) begin
               state_in = bhah_pkg::ST_IDLE;
            end
         end
         default: state_in = bhah_pkg::ST_IDLE;
      endcase
   end

   // Handshake and table controls
   always_comb begin
      req_chan.ready = (state_ff == bhah_pkg::ST_IDLE);
      csr_chan.ready = 1'b1;
      ram_we = (state_ff == bhah_pkg::ST_CHECK) && (kind_ff == bhah_pkg::KIND_ADD) &&
               !(hit.hit_a || hit.hit_b) && region_last;
      ram_re = (state_ff == bhah_pkg::ST_OVF_READ) ||
               ((state_ff == bhah_pkg::ST_OVF_ROUND) && idx_live);
   end

   // Datapath next values
   always_comb begin
      heap_base_in  = heap_base_ff;
      heap_limit_in = heap_limit_ff;
      image_end_in  = image_end_ff;
      heap_ptr_in   = heap_ptr_ff;
      ovf_bytes_in  = ovf_bytes_ff;
      open_idx_in   = open_idx_ff;
      open_count_in = open_count_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      align_in      = align_ff;
      cand_in       = cand_ff;
      cand_end_in   = cand_end_ff;
      region_in     = region_ff;
      jumped_in     = jumped_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         // Latch the transaction; an add-block checks its own bounds
         bhah_pkg::ST_IDLE: begin
            if (req_fire) begin
               kind_in       = req_chan.kind;
               size_in       = req_chan.request_size;
               align_in      = req_chan.align_bytes;
               cand_in       = req_chan.block_first;
               cand_end_in   = req_chan.block_limit;
               region_in     = '0;
               jumped_in     = 1'b0;
               res_addr_in   = '0;
               res_status_in = bhah_pkg::STAT_REFUSED;
            end
         end
         bhah_pkg::ST_ROUND: cand_in = bhah_pkg::round_up(heap_ptr_ff, align_ff);
         bhah_pkg::ST_SUM: begin
            cand_end_in = cand_ff + size_ff;
            region_in   = '0;
         end
         // Scan the regions against both ends
         bhah_pkg::ST_CHECK: begin
            if (hit.hit_a || hit.hit_b) begin
               cand_in   = cand_end_ff;
               region_in = '0;
               jumped_in = 1'b1;
            end else if (region_last) begin
               if (kind_ff == bhah_pkg::KIND_ADD) begin
                  open_count_in = open_count_ff + CNT_W'(1);
                  res_status_in = bhah_pkg::STAT_HEAP;
               end
            end else begin
               region_in = region_ff + RC_W'(1);
            end
         end
         // Skip reserved regions; restart at the second region after a jump
         bhah_pkg::ST_JUMP: begin
            if (!region_end) begin
               if (hit.hit_a) begin
                  cand_in   = hit.hi;
                  region_in = RC_W'(1);
               end else begin
                  region_in = region_ff + RC_W'(1);
               end
            end
         end
         // Grant from the heap or enter overflow mode
         bhah_pkg::ST_COMMIT: begin
            if (cand_end_ff >= heap_limit_ff) begin
               ovf_bytes_in = ovf_bytes_ff + size_ff;
               open_idx_in  = '0;
            end else begin
               heap_ptr_in   = cand_end_ff;
               res_addr_in   = cand_ff;
               res_status_in = bhah_pkg::STAT_HEAP;
            end
         end
         // Load the block start; an empty table reads as zero
         bhah_pkg::ST_OVF_LOAD: begin
            if (idx_live) begin
               heap_ptr_in = ram_entry.blk_first;
            end else if (open_idx_ff == '0) begin
               heap_ptr_in = '0;
            end
         end
         bhah_pkg::ST_OVF_ROUND: begin
            if (idx_live) begin
               cand_in = bhah_pkg::round_up(heap_ptr_ff, align_ff);
            end else begin
               res_addr_in   = '0;
               res_status_in = bhah_pkg::STAT_NO_MEM;
            end
         end
         bhah_pkg::ST_OVF_SUM: cand_end_in = cand_ff + size_ff;
         bhah_pkg::ST_OVF_TEST: begin
            if (ram_entry.blk_limit >= cand_end_ff) begin
               heap_ptr_in   = cand_end_ff;
               ovf_bytes_in  = ovf_bytes_ff + size_ff;
               res_addr_in   = cand_ff;
               res_status_in = bhah_pkg::STAT_OVERFLOW;
            end else begin
               open_idx_in = open_idx_ff + CNT_W'(1);
            end
         end
         // Move the result to the output register
         bhah_pkg::ST_DONE: begin
            if (done_xfer) begin
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_valid_in  = 1'b1;
            end
         end
         default: ;
      endcase

      // Register writes; heap base also reloads the pointer
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            bhah_pkg::CSR_HEAP_BASE: begin
               heap_base_in = csr_chan.data;
               heap_ptr_in  = csr_chan.data;
            end
            bhah_pkg::CSR_HEAP_LIMIT: heap_limit_in = csr_chan.data;
            bhah_pkg::CSR_IMAGE_END:  image_end_in  = csr_chan.data;
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bhah_pkg::ST_IDLE;
         heap_base_ff  <= bhah_pkg::HEAP_BASE_RST;
         heap_limit_ff <= bhah_pkg::HEAP_LIMIT_RST;
         image_end_ff  <= bhah_pkg::IMAGE_END_RST;
         heap_ptr_ff   <= bhah_pkg::HEAP_BASE_RST;
         ovf_bytes_ff  <= '0;
         open_idx_ff   <= '0;
         open_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         heap_base_ff  <= heap_base_in;
         heap_limit_ff <= heap_limit_in;
         image_end_ff  <= image_end_in;
         heap_ptr_ff   <= heap_ptr_in;
         ovf_bytes_ff  <= ovf_bytes_in;
         open_idx_ff   <= open_idx_in;
         open_count_ff <= open_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      align_ff      <= align_in;
      cand_ff       <= cand_in;
      cand_end_ff   <= cand_end_in;
      region_ff     <= region_in;
      jumped_ff     <= jumped_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.granted_address = rsp_addr_ff;
   assign rsp_chan.status          = rsp_status_ff;

   // Checks
   `BHAH_ASSERT_ALWAYS(a_idx_within_count, clock, reset,
                       open_idx_ff <= open_count_ff, "open index passed open count")
   `BHAH_ASSERT_ALWAYS(a_count_bound, clock, reset,
                       open_count_ff <= CNT_W'(OPEN_BLOCKS), "open count passed table depth")
   `BHAH_ASSERT_NEXT(a_busy_after_accept, clock, reset,
                     req_fire, !req_chan.ready, "accepted a transaction while busy")

endmodule

FILE: bench/bump_heap_allocator_with_holes_core_tb.sv
// Self-checking bench for the bump heap allocator: random and directed allocate and
// add-block transactions, register phases, and a scoreboard that predicts each grant.
// Depends on bhah_pkg, the channel interfaces of bhah_if.sv and the allocator core.
module bump_heap_allocator_with_holes_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef bhah_pkg::addr_type    addr_type;
   typedef bhah_pkg::align_type   align_type;
   typedef bhah_pkg::status_type  status_type;
   typedef bhah_pkg::csr_idx_type csr_idx_type;

   localparam int unsigned N_BLOCKS  = bhah_pkg::OPEN_BLOCKS_DEF;
   localparam int unsigned N_HOLES   = bhah_pkg::RESERVED_REGIONS_DEF;
   localparam int unsigned SHOW_MAX  = 10;
   localparam int unsigned DRAIN_MAX = 20000;

   typedef struct {
      logic      kind;
      addr_type  req_size;
      align_type align;
      addr_type  blk_lo;
      addr_type  blk_hi;
   } heap_req_type;

   typedef struct {
      addr_type   addr;
      status_type status;
   } grant_type;

   // Tracks allocator state, predicts each grant and checks it in order
   class grant_scoreboard;
      addr_type    base_reg;
      addr_type    limit_reg;
      addr_type    image_end_reg;
      addr_type    heap_ptr;
      addr_type    ovf_bytes;
      int unsigned open_idx;
      int unsigned open_cnt;
      addr_type    blk_start [N_BLOCKS];
      addr_type    blk_end   [N_BLOCKS];
      grant_type   due [$];
      int unsigned errors;

      function new();
         base_reg      = bhah_pkg::HEAP_BASE_RST;
         limit_reg     = bhah_pkg::HEAP_LIMIT_RST;
         image_end_reg = bhah_pkg::IMAGE_END_RST;
         heap_ptr      = bhah_pkg::HEAP_BASE_RST;
         ovf_bytes     = '0;
         open_idx      = 0;
         open_cnt      = 0;
         errors        = 0;
         foreach (blk_start[i]) begin
            blk_start[i] = '0;
            blk_end[i]   = '0;
         end
      endfunction

      function void write_reg(csr_idx_type idx, addr_type val);
         case (idx)
            bhah_pkg::CSR_HEAP_BASE: begin
               base_reg = val;
               heap_ptr = val;
            end
            bhah_pkg::CSR_HEAP_LIMIT: limit_reg     = val;
            bhah_pkg::CSR_IMAGE_END:  image_end_reg = val;
            default: ;
         endcase
      endfunction

      function addr_type hole_lo(int unsigned r);
         case (r)
            0: return 32'h800D_A800;
            1: return 32'h8010_0000;
            2: return 32'h803D_A800;
            3: return 32'h8000_0400;
            4: return 32'h8020_0000;
            5: return 32'h8000_0000;
            default: return '0;
         endcase
      endfunction

      // The image region ends where the register says
      function addr_type hole_hi(int unsigned r);
         case (r)
            0: return 32'h8010_0000;
            1: return 32'h8012_5800;
            2: return 32'h8040_0000;
            3: return 32'h8004_17DC;
            4: return image_end_reg;
            5: return 32'h8000_0400;
            default: return '0;
         endcase
      endfunction

      function bit in_hole(addr_type a, int unsigned r);
         return a >= hole_lo(r) && a < hole_hi(r);
      endfunction

      function bit clear_of_holes(addr_type lo, addr_type hi);
         for (int unsigned r = 0; r < N_HOLES; r++)
            if (in_hole(lo, r) || in_hole(hi, r)) return 1'b0;
         return 1'b1;
      endfunction

      // Hop over holes; after each hop rescan from the second region
      function addr_type skip_holes(addr_type a);
         int unsigned r;
         r = 0;
         while (r < N_HOLES) begin
            if (in_hole(a, r)) begin
               a = hole_hi(r);
               r = 1;
            end else begin
               r++;
            end
         end
         return a;
      endfunction

      function addr_type align_up(addr_type p, align_type a);
         addr_type span;
         span = (a == '0) ? addr_type'(1) : addr_type'(a);
         return (p + span - 1) & ~(span - 1);
      endfunction

      // Walk the open-block table from the current index
      function grant_type serve_overflow(addr_type nbytes, align_type a);
         grant_type g;
         addr_type  s;
         addr_type  e;
         while (open_idx < open_cnt && open_idx < N_BLOCKS) begin
            s = align_up(heap_ptr, a);
            e = s + nbytes;
            if (blk_end[open_idx] >= e) begin
               heap_ptr  = e;
               ovf_bytes = ovf_bytes + nbytes;
               g.addr    = s;
               g.status  = bhah_pkg::STAT_OVERFLOW;
               return g;
            end
            open_idx++;
            if (open_idx < open_cnt && open_idx < N_BLOCKS) heap_ptr = blk_start[open_idx];
         end
         g.addr   = '0;
         g.status = bhah_pkg::STAT_NO_MEM;
         return g;
      endfunction

      function grant_type predict(heap_req_type t);
         grant_type g;
         addr_type  s;
         if (t.kind == bhah_pkg::KIND_ADD) begin
            g.addr = '0;
            if (t.blk_lo != t.blk_hi && open_cnt < N_BLOCKS &&
                clear_of_holes(t.blk_lo, t.blk_hi)) begin
               blk_start[open_cnt] = t.blk_lo;
               blk_end[open_cnt]   = t.blk_hi;
               open_cnt++;
               g.status = bhah_pkg::STAT_HEAP;
            end else begin
               g.status = bhah_pkg::STAT_REFUSED;
            end
            return g;
         end
         if (ovf_bytes != '0) return serve_overflow(t.req_size, t.align);
         s = align_up(heap_ptr, t.align);
         if (!clear_of_holes(s, s + t.req_size)) s = skip_holes(s + t.req_size);
         heap_ptr = s + t.req_size;
         // Past the limit: switch to the open-block table
         if (heap_ptr >= limit_reg) begin
            heap_ptr  = blk_start[0];
            ovf_bytes = ovf_bytes + t.req_size;
            open_idx  = 0;
            return serve_overflow(t.req_size, t.align);
         end
         g.addr   = s;
         g.status = bhah_pkg::STAT_HEAP;
         return g;
      endfunction

      function void note(heap_req_type t);
         due.push_back(predict(t));
      endfunction

      function void check(grant_type got);
         grant_type want;
         if (due.size() == 0) begin
            errors++;
            if (errors <= SHOW_MAX)
               $display("[%0t] unexpected grant: addr %h status %0d",
                        $time, got.addr, got.status);
            return;
         end
         want = due.pop_front();
         if (got.addr !== want.addr || got.status !== want.status) begin
            errors++;
            if (errors <= SHOW_MAX)
               $display("[%0t] grant mismatch: addr exp %h got %h, status exp %0d got %0d",
                        $time, want.addr, got.addr, want.status, got.status);
         end
      endfunction
   endclass

   logic        clock  = 1'b0;
   logic        reset  = 1'b1;
   bit          steady = 1'b0;
   int unsigned sent   = 0;

   grant_scoreboard grants = new();

   bhah_req_if req_if ();
   bhah_rsp_if rsp_if ();
   bhah_csr_if csr_if ();

   bump_heap_allocator_with_holes_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   function automatic int unsigned pause_len();
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic heap_req_type mk_alloc(addr_type nbytes, align_type a);
      heap_req_type t;
      t.kind     = bhah_pkg::KIND_ALLOC;
      t.req_size = nbytes;
      t.align    = a;
      t.blk_lo   = $urandom;
      t.blk_hi   = $urandom;
      return t;
   endfunction

   function automatic heap_req_type mk_block(addr_type lo, addr_type hi);
      heap_req_type t;
      t.kind     = bhah_pkg::KIND_ADD;
      t.req_size = $urandom;
      t.align    = align_type'($urandom_range(0, 17'h1FFFF));
      t.blk_lo   = lo;
      t.blk_hi   = hi;
      return t;
   endfunction

   // Mostly powers of two, with zero and arbitrary values mixed in
   function automatic align_type pick_align();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return align_type'($urandom_range(0, 17'h1FFFF));
         default: return align_type'(1) << $urandom_range(0, 16);
      endcase
   endfunction

   function automatic addr_type heap_size();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return '0;
      if (pick < 12) return $urandom;
      if (pick < 70) return $urandom_range(1, 32'h400);
      return $urandom_range(32'h400, 32'h4_0000);
   endfunction

   // Block that must be refused: empty, or an end inside a fixed hole
   function automatic heap_req_type odd_block();
      addr_type a;
      addr_type b;
      addr_type h;
      case ($urandom_range(0, 4))
         0: h = 32'h800D_A800;
         1: h = 32'h8010_0000;
         2: h = 32'h803D_A800;
         3: h = 32'h8000_0400;
         default: h = 32'h8000_0000;
      endcase
      h = h + $urandom_range(0, 32'h3FF);
      a = $urandom;
      b = a;
      case ($urandom_range(0, 2))
         0: ;
         1: a = h;
         default: b = h;
      endcase
      return mk_block(a, b);
   endfunction

   function automatic heap_req_type open_block();
      addr_type a;
      a = 32'h9000_0000 + ($urandom_range(0, 255) << 20);
      return mk_block(a, a + $urandom_range(32'h100, 32'h4_0000));
   endfunction

   // Present one transaction after a random gap; keep valid high on back-to-back
   task automatic issue(heap_req_type t);
      int unsigned gap;
      if (sent % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      sent++;
      gap = pause_len();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.kind         <= t.kind;
      req_if.request_size <= t.req_size;
      req_if.align_bytes  <= t.align;
      req_if.block_first  <= t.blk_lo;
      req_if.block_limit  <= t.blk_hi;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      grants.note(t);
   endtask

   task automatic write_csr(csr_idx_type idx, addr_type val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      grants.write_reg(idx, val);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off the sender until every grant is back and the core is idle
   task automatic settle();
      req_if.valid <= 1'b0;
      while (grants.due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_directed();
      issue(mk_alloc(32'h10, 17'd1));
      issue(mk_alloc(32'h0, 17'd0));
      issue(mk_alloc(32'h24, 17'd12));
      issue(mk_alloc(32'h100, 17'h1_0000));
      issue(mk_alloc(32'h9_0000, 17'd4));
      issue(mk_alloc(32'h1, 17'h1_FFFF));
      issue(mk_block(32'h9000_0000, 32'h9000_0000));
      issue(mk_block(32'h8000_0000, 32'h9000_0000));
      issue(mk_block(32'h7000_0000, 32'h8010_0010));
      issue(mk_block(32'h9000_0000, 32'h9010_0000));
      issue(mk_block(32'hFFFF_FFFF, 32'h0000_0000));
      issue(mk_block(32'h0000_0000, 32'h0000_1000));
      issue(mk_alloc(32'hFFFF_FFFF, 17'd1));
      issue(mk_alloc(32'h1000, 17'd2));
      issue(mk_alloc(32'h8000, 17'h100));
      issue(mk_alloc(32'h0, 17'd1));
      issue(mk_alloc(32'h20, 17'h20));
   endtask

   task automatic run_heap(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 12) issue(odd_block());
         else issue(mk_alloc(heap_size(), pick_align()));
      end
   endtask

   // With a zero limit every zero-size allocate goes through the block table
   task automatic run_zero_limit(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0:       issue(open_block());
            1, 2:    issue(odd_block());
            default: issue(mk_alloc('0, pick_align()));
         endcase
      end
   endtask

   task automatic run_overflow(int unsigned n);
      int unsigned pick;
      for (int unsigned i = 0; i < n; i++) begin
         pick = $urandom_range(0, 199);
         if (pick < 10)       issue(open_block());
         else if (pick < 12)  issue(mk_block($urandom, $urandom));
         else if (pick < 14)  issue(odd_block());
         else if (pick == 14) issue(mk_alloc($urandom, pick_align()));
         else if (pick < 25)  issue(mk_alloc($urandom_range(0, 32'h4_0000), pick_align()));
         else                 issue(mk_alloc($urandom_range(0, 32'h2000), pick_align()));
      end
   endtask

   // Response side: random back-pressure, check each accepted grant
   initial begin
      grant_type   got;
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pause_len();
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (rsp_if.valid !== 1'b1) @(posedge clock);
         got.addr   = rsp_if.granted_address;
         got.status = rsp_if.status;
         grants.check(got);
      end
   end

   // Stimulus: directed opening, heap phases, a zero-limit phase, then the overflow phase
   initial begin
      req_if.valid        <= 1'b0;
      req_if.kind         <= bhah_pkg::KIND_ALLOC;
      req_if.request_size <= '0;
      req_if.align_bytes  <= '0;
      req_if.block_first  <= '0;
      req_if.block_limit  <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= bhah_pkg::CSR_HEAP_BASE;
      csr_if.data         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      settle();
      write_csr(bhah_pkg::CSR_HEAP_BASE, '0);
      write_csr(bhah_pkg::CSR_HEAP_LIMIT, '1);
      write_csr(bhah_pkg::CSR_IMAGE_END, '1);
      run_heap(130);

      // Walk through every hole from the bottom of the reserved area
      settle();
      write_csr(bhah_pkg::CSR_HEAP_BASE, 32'h8000_0000);
      write_csr(bhah_pkg::CSR_IMAGE_END, 32'h8030_0000);
      run_heap(160);

      settle();
      write_csr(bhah_pkg::CSR_HEAP_BASE, '1);
      write_csr(bhah_pkg::CSR_IMAGE_END, '0);
      run_heap(130);

      settle();
      write_csr(bhah_pkg::CSR_HEAP_BASE, $urandom);
      write_csr(bhah_pkg::CSR_IMAGE_END, $urandom);
      run_heap(130);

      settle();
      write_csr(bhah_pkg::CSR_HEAP_BASE, $urandom);
      write_csr(bhah_pkg::CSR_HEAP_LIMIT, '0);
      write_csr(bhah_pkg::CSR_IMAGE_END, bhah_pkg::IMAGE_END_RST);
      run_zero_limit(40);

      // Small heap so the allocator soon lives off the open blocks
      settle();
      write_csr(bhah_pkg::CSR_HEAP_BASE, 32'hA000_0000);
      write_csr(bhah_pkg::CSR_HEAP_LIMIT, 32'hA000_8000);
      run_overflow(700);

      req_if.valid <= 1'b0;
      for (int i = 0; i < DRAIN_MAX && grants.due.size() != 0; i++) @(posedge clock);
      repeat (20) @(posedge clock);
      grants.errors += grants.due.size();
      if (grants.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
